// ===== rtl/fgie_pkg.sv =====
// Package for the frame gain index estimator: sequencer types, sizes and gain table.
package fgie_pkg;

    localparam int MAX_FRAME  = 1024;
    localparam int GAIN_COUNT = 16;
    localparam int CNT_W      = $clog2(MAX_FRAME + 1);
    localparam int ACC_W      = 48;
    localparam int THR_W      = 21;
    localparam int MUL_W      = 26;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int WIDE_W     = 70;
    localparam int HALF_W     = 24;
    localparam logic [THR_W-1:0] THR_RESET = 21'd8250;
    localparam logic [8:0]       GAIN_ONE  = 9'd256;
    localparam logic [3:0]       IDX_LAST  = 4'(GAIN_COUNT - 1);
    localparam logic [3:0]       IDX_CLAMP = 4'(GAIN_COUNT - 2);

    typedef enum logic [3:0] {
        ST_IDLE, ST_MOO, ST_MRR, ST_MDD, ST_MOR, ST_ACC, ST_END,
        ST_WLO, ST_WHI, ST_WSUM, ST_EVAL, ST_SQSTART, ST_SQT, ST_SQLOAD, ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        MD_GATE, MD_SRCH, MD_SQRT
    } t_mode;

    // Candidate gains in Q16.
    function automatic logic [16:0] gain_k(input logic [3:0] j);
        logic [16:0] k;
        unique case (j)
            4'd0:  k = 17'd65536;
            4'd1:  k = 17'd60855;
            4'd2:  k = 17'd56174;
            4'd3:  k = 17'd51494;
            4'd4:  k = 17'd46813;
            4'd5:  k = 17'd42132;
            4'd6:  k = 17'd37451;
            4'd7:  k = 17'd32771;
            4'd8:  k = 17'd28090;
            4'd9:  k = 17'd23409;
            4'd10: k = 17'd18728;
            4'd11: k = 17'd14048;
            4'd12: k = 17'd9367;
            4'd13: k = 17'd4686;
            4'd14: k = 17'd5;
            4'd15: k = 17'd0;
            default: k = 17'd0;
        endcase
        return k;
    endfunction

    // Sum of two neighboring gains, the midpoint test weight.
    function automatic logic [THR_W-1:0] gain_ksum(input logic [3:0] j);
        return THR_W'({1'b0, gain_k(j)} + {1'b0, gain_k(j + 4'd1)});
    endfunction

endpackage

// ===== rtl/fgie_mul.sv =====
// Shared signed multiplier with registered product.
module fgie_mul
    import fgie_pkg::*;
(
    input  logic                     i_clk,
    input  logic signed [MUL_W-1:0]  i_a,
    input  logic signed [MUL_W-1:0]  i_b,
    output logic signed [PROD_W-1:0] o_p
);

    logic signed [PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

// ===== rtl/frame_gain_index_estimator.sv =====
// Top level of the frame gain index estimator: sequencer, sums and result register.
//
// Usage: send one channel frame as pairs of Q15 samples on the input channel
// (i_in_valid / o_in_stall); the sample with i_last_sample set closes the frame.
// Each frame yields one result on the output channel (o_out_valid / i_out_stall):
// channel, gain index, Q8 gain and the gate flag.
// One signed multiplier is shared by all products under a small sequencer.
// Each sample is taken in its transfer cycle and then passes through four products and
// one accumulate through the multiplier; samples past MAX_FRAME are not accumulated.
// Frame close, at most: the last sample's own products, the gate test, one weighted
// product per gain candidate tested, the eight-bit root search one bit at a time,
// and then the load of the result register; a silent original skips the gate test,
// and a frame that passes the gate test skips the search and the root search.
// The block takes no sample while it works; o_in_stall is high then.
// The result is held in an output register; if the receiver stalls it, the
// next frame may still stream in, and a frame close waits for that register.
// The threshold register is written through i_cfg_valid / o_cfg_ready; write it only
// at idle time, the block itself does not enforce this. o_cfg_ready is always high.
// Reset (synchronous, active low) clears the sums, the sequencer and the
// output valid, and loads the threshold with 8250 (about -9 dB).
module frame_gain_index_estimator
    import fgie_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [15:0] i_orig_sample,
    input  logic signed [15:0] i_recon_sample,
    input  logic [3:0]         i_channel_number,
    input  logic               i_last_sample,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [3:0]         o_channel_out,
    output logic [3:0]         o_gain_index,
    output logic [8:0]         o_gain_q8,
    output logic               o_gated,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [THR_W-1:0]   i_cfg_data
);

    t_state r_state, n_state;
    t_mode  r_mode,  n_mode;
    logic signed [15:0] r_o, n_o, r_r, n_r;
    logic [3:0]  r_chan, n_chan;
    logic        r_last, n_last;
    logic [ACC_W-1:0] r_eo, n_eo, r_er, n_er, r_en, n_en, r_c, n_c;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [THR_W-1:0] r_thr;
    logic [THR_W-1:0] r_mul_a, n_mul_a;
    logic [ACC_W-1:0] r_wlo, n_wlo;
    logic [WIDE_W-1:0] r_wide, n_wide;
    logic [3:0]  r_j, n_j, r_best, n_best;
    logic [7:0]  r_q, n_q, r_bit, n_bit;
    logic [8:0]  r_gain, n_gain;
    logic        r_gated, n_gated;
    logic        r_ov, n_ov;
    logic [3:0]  r_och, n_och, r_oidx, n_oidx;
    logic [8:0]  r_ogain, n_ogain;
    logic        r_ogated, n_ogated;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;
    logic [ACC_W-1:0]  wide_b;
    logic signed [71:0] lhs_s, rhs_s;
    logic [WIDE_W-1:0] en_sh, eo_sh;
    logic [7:0]  tq;
    logic        in_xfer;

    fgie_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    assign in_xfer     = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_ov;
    assign o_channel_out = r_och;
    assign o_gain_index  = r_oidx;
    assign o_gain_q8     = r_ogain;
    assign o_gated       = r_ogated;

    // The wide products multiply by Eo for the gate test and by Er otherwise.
    assign wide_b = (r_mode == MD_GATE) ? r_eo : r_er;
    assign tq     = r_q | r_bit;
    assign lhs_s  = signed'({2'b00, r_wide});
    assign rhs_s  = signed'({{24{r_c[ACC_W-1]}}, r_c}) <<< 17;
    assign en_sh  = {{(WIDE_W - ACC_W){1'b0}}, r_en} << 16;
    assign eo_sh  = {{(WIDE_W - ACC_W){1'b0}}, r_eo} << 16;

    // Multiplier operand select by sequencer step.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            ST_MOO: begin
                mul_a = MUL_W'(r_o);
                mul_b = MUL_W'(r_o);
            end
            ST_MRR: begin
                mul_a = MUL_W'(r_r);
                mul_b = MUL_W'(r_r);
            end
            ST_MDD: begin
                mul_a = MUL_W'(17'(r_o) - 17'(r_r));
                mul_b = MUL_W'(17'(r_o) - 17'(r_r));
            end
            ST_MOR: begin
                mul_a = MUL_W'(r_o);
                mul_b = MUL_W'(r_r);
            end
            ST_WLO: begin
                mul_a = signed'({{(MUL_W - THR_W){1'b0}}, r_mul_a});
                mul_b = signed'({{(MUL_W - HALF_W){1'b0}}, wide_b[HALF_W-1:0]});
            end
            ST_WHI: begin
                mul_a = signed'({{(MUL_W - THR_W){1'b0}}, r_mul_a});
                mul_b = signed'({{(MUL_W - HALF_W){1'b0}}, wide_b[ACC_W-1:HALF_W]});
            end
            ST_SQT: begin
                mul_a = signed'({{(MUL_W - 8){1'b0}}, tq});
                mul_b = signed'({{(MUL_W - 8){1'b0}}, tq});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Sequencer: next state and datapath updates.
    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        n_o = r_o;  n_r = r_r;  n_chan = r_chan;  n_last = r_last;
        n_eo = r_eo;  n_er = r_er;  n_en = r_en;  n_c = r_c;
        n_cnt = r_cnt;
        n_mul_a = r_mul_a;
        n_wlo = r_wlo;  n_wide = r_wide;
        n_j = r_j;  n_best = r_best;
        n_q = r_q;  n_bit = r_bit;
        n_gain = r_gain;  n_gated = r_gated;
        n_och = r_och;  n_oidx = r_oidx;  n_ogain = r_ogain;  n_ogated = r_ogated;
        // Drop the held result once the receiver takes it.
        n_ov = r_ov && i_out_stall;

        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_o    = i_orig_sample;
                    n_r    = i_recon_sample;
                    n_chan = i_channel_number;
                    n_last = i_last_sample;
                    if (r_cnt < CNT_W'(MAX_FRAME)) begin
                        n_state = ST_MOO;
                    end else if (i_last_sample) begin
                        n_state = ST_END;
                    end
                end
            end
            ST_MOO: n_state = ST_MRR;
            ST_MRR: begin
                n_eo    = r_eo + prod[ACC_W-1:0];
                n_state = ST_MDD;
            end
            ST_MDD: begin
                n_er    = r_er + prod[ACC_W-1:0];
                n_state = ST_MOR;
            end
            ST_MOR: begin
                n_en    = r_en + prod[ACC_W-1:0];
                n_state = ST_ACC;
            end
            ST_ACC: begin
                n_c     = r_c + prod[ACC_W-1:0];
                n_cnt   = r_cnt + 1'b1;
                n_state = r_last ? ST_END : ST_IDLE;
            end
            ST_END: begin
                // Silent original gates at once; otherwise test En*2^16 > thr*Eo.
                if (r_eo == '0) begin
                    n_gated = 1'b1;
                    n_j     = 4'd0;
                    n_mul_a = gain_ksum(4'd0);
                    n_mode  = MD_SRCH;
                end else begin
                    n_mul_a = r_thr;
                    n_mode  = MD_GATE;
                end
                n_state = ST_WLO;
            end
            ST_WLO: n_state = ST_WHI;
            ST_WHI: begin
                n_wlo   = prod[ACC_W-1:0];
                n_state = ST_WSUM;
            end
            ST_WSUM: begin
                n_wide  = {{(WIDE_W - ACC_W){1'b0}}, r_wlo}
                        + ({{(WIDE_W - ACC_W){1'b0}}, prod[ACC_W-1:0]} << HALF_W);
                n_state = ST_EVAL;
            end
            ST_EVAL: begin
                unique case (r_mode)
                    MD_GATE: begin
                        if (en_sh > r_wide) begin
                            n_gated = 1'b1;
                            n_j     = 4'd0;
                            n_mul_a = gain_ksum(4'd0);
                            n_mode  = MD_SRCH;
                            n_state = ST_WLO;
                        end else begin
                            n_gated = 1'b0;
                            n_best  = 4'd0;
                            n_gain  = GAIN_ONE;
                            n_state = ST_DONE;
                        end
                    end
                    MD_SRCH: begin
                        // First midpoint at or below 2^17*C wins.
                        if (lhs_s <= rhs_s) begin
                            n_best  = r_j;
                            n_state = ST_SQSTART;
                        end else if (r_j == IDX_CLAMP) begin
                            n_best  = IDX_LAST;
                            n_state = ST_SQSTART;
                        end else begin
                            n_j     = r_j + 4'd1;
                            n_mul_a = gain_ksum(r_j + 4'd1);
                            n_state = ST_WLO;
                        end
                    end
                    MD_SQRT: begin
                        if (r_wide <= eo_sh) begin
                            n_q = tq;
                        end
                        if (r_bit == 8'd1) begin
                            n_gain  = {1'b0, (r_wide <= eo_sh) ? tq : r_q};
                            n_state = ST_DONE;
                        end else begin
                            n_bit   = r_bit >> 1;
                            n_state = ST_SQT;
                        end
                    end
                    default: n_state = ST_DONE;
                endcase
            end
            ST_SQSTART: begin
                if (r_er == '0 || r_eo >= r_er) begin
                    n_gain  = GAIN_ONE;
                    n_state = ST_DONE;
                end else begin
                    n_q     = 8'd0;
                    n_bit   = 8'd128;
                    n_state = ST_SQT;
                end
            end
            ST_SQT: n_state = ST_SQLOAD;
            ST_SQLOAD: begin
                n_mul_a = prod[THR_W-1:0];
                n_mode  = MD_SQRT;
                n_state = ST_WLO;
            end
            ST_DONE: begin
                // Hold until the result register is free, then load and clear sums.
                if (!n_ov) begin
                    n_ov     = 1'b1;
                    n_och    = r_chan;
                    n_ogated = r_gated;
                    n_oidx   = r_best;
                    n_ogain  = r_gain;
                    if (r_best == IDX_LAST) begin
                        if (r_eo != '0) begin
                            n_oidx = IDX_CLAMP;
                        end else begin
                            n_ogain = 9'd0;
                        end
                    end
                    n_eo = '0;  n_er = '0;  n_en = '0;  n_c = '0;
                    n_cnt   = '0;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_mode  <= MD_GATE;
            r_eo    <= '0;
            r_er    <= '0;
            r_en    <= '0;
            r_c     <= '0;
            r_cnt   <= '0;
            r_best  <= 4'd0;
            r_ov    <= 1'b0;
            r_thr   <= THR_RESET;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_eo    <= n_eo;
            r_er    <= n_er;
            r_en    <= n_en;
            r_c     <= n_c;
            r_cnt   <= n_cnt;
            r_best  <= n_best;
            r_ov    <= n_ov;
            if (i_cfg_valid && o_cfg_ready) begin
                r_thr <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_o      <= n_o;
        r_r      <= n_r;
        r_chan   <= n_chan;
        r_last   <= n_last;
        r_mul_a  <= n_mul_a;
        r_wlo    <= n_wlo;
        r_wide   <= n_wide;
        r_j      <= n_j;
        r_q      <= n_q;
        r_bit    <= n_bit;
        r_gain   <= n_gain;
        r_gated  <= n_gated;
        r_och    <= n_och;
        r_oidx   <= n_oidx;
        r_ogain  <= n_ogain;
        r_ogated <= n_ogated;
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_FRAME))
        else $error("frame count past bound");

    a_gain_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_gain_q8 <= GAIN_ONE))
        else $error("gain above unity");

    a_ungated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_gated) |-> (o_gain_index == 4'd0 && o_gain_q8 == GAIN_ONE))
        else $error("ungated result not unity");

    a_zero_gain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_gain_index == IDX_LAST) |-> (o_gain_q8 == 9'd0))
        else $error("last index with nonzero gain");

endmodule
